// ===== rtl/queue_event_statistics_assert.svh =====
`ifndef QUEUE_EVENT_STATISTICS_ASSERT_SVH
`define QUEUE_EVENT_STATISTICS_ASSERT_SVH

// same-cycle implication, reset masked
`define QES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define QES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qes_pkg.sv =====
package qes_pkg;

    localparam int FIFO_DEPTH = 1024;
    localparam int TIME_W     = 48;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
    localparam int ACC_W      = 64;
    localparam int CNT_W      = 32;
    localparam int CAP_W      = 10;
    localparam int HOR_W      = 48;
    localparam int PROD_W     = OCC_W + TIME_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_CAP_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SERVED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON      = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [TIME_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } ram_req_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== rtl/queue_event_statistics.sv =====
// An accepted input word passes through ST_CALC and ST_ACC to ST_OUT, where the result word is loaded.
// One event is taken at a time (capture and RAM read, state update, accumulate,
// output load); in_stall stays high until the result word is loaded.
// A result word held by out_stall keeps the next event waiting in ST_OUT.
// Reset (rst_n, async low) clears pointers, counters, accumulators and config
// to defaults; arrival RAM contents are undefined until written.
`include "queue_event_statistics_assert.svh"

module queue_event_statistics (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [qes_pkg::TIME_W-1:0]      event_time,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            accepted,
    output logic                            start_service,
    output logic                            empty_departure,
    output logic [qes_pkg::TIME_W-1:0]      delay,
    output logic [qes_pkg::OCC_W-1:0]       in_system,
    output logic [qes_pkg::ACC_W-1:0]       area_queue,
    output logic [qes_pkg::ACC_W-1:0]       area_busy,
    output logic [qes_pkg::ACC_W-1:0]       total_delay,
    output logic [qes_pkg::CNT_W-1:0]       served_count,
    output logic [qes_pkg::TIME_W-1:0]      warmup_end_time,
    output logic                            terminate,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qes_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import qes_pkg::*;

    state_t state_reg, state_next;

    logic              cap_enable_reg;
    logic [CAP_W-1:0]  cap_limit_reg;
    logic [CNT_W-1:0]  warmup_count_reg;
    logic              term_mode_reg;
    logic [CNT_W-1:0]  max_served_reg;
    logic [HOR_W-1:0]  horizon_reg;

    logic [PTR_W-1:0]  head_ptr_reg, tail_ptr_reg;
    logic [OCC_W-1:0]  occupancy_reg;
    logic              server_busy_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic [CNT_W-1:0]  served_all_reg, served_post_reg;
    logic [ACC_W-1:0]  queue_area_reg, busy_area_reg, delay_sum_reg;
    logic [TIME_W-1:0] warm_end_reg;

    logic              ev_dep_reg;
    logic [TIME_W-1:0] ev_time_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [TIME_W-1:0] busy_inc_reg;
    logic [TIME_W-1:0] delay_add_reg;

    logic              res_acc_reg, res_start_reg, res_empty_reg;
    logic [TIME_W-1:0] res_delay_reg;

    logic              out_valid_reg;
    logic              o_acc_reg, o_start_reg, o_empty_reg, o_term_reg;
    logic [TIME_W-1:0] o_delay_reg, o_warm_reg;
    logic [OCC_W-1:0]  o_occ_reg;
    logic [ACC_W-1:0]  o_aq_reg, o_ab_reg, o_td_reg;
    logic [CNT_W-1:0]  o_served_reg;

    logic              in_fire, out_load, cfg_fire;
    ram_req_t          ram_req;
    logic [TIME_W-1:0] ram_rdata;

    // event decode in the CALC cycle
    logic              warm_pre, integ, reject, busy_now;
    logic [TIME_W-1:0] dt, dep_delay;
    logic [OCC_W-1:0]  waiting, occ_dec;
    logic [CNT_W-1:0]  served_all_inc;
    logic              warm_post;
    logic [ACC_W+PROD_W-1:0] prod_ext;
    logic [ACC_W-1:0]  prod_sat;
    logic              term;

    // ---------------- fsm ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_CALC;
            ST_CALC: state_next = ST_ACC;
            ST_ACC:  state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    end

    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- config ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_enable_reg   <= 1'b0;
            cap_limit_reg    <= CAP_W'(1023);
            warmup_count_reg <= CNT_W'(10);
            term_mode_reg    <= 1'b1;
            max_served_reg   <= CNT_W'(10000);
            horizon_reg      <= HOR_W'(10000);
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_CAP_ENABLE:   cap_enable_reg   <= cfg_data[0];
                CFG_CAP_LIMIT:    cap_limit_reg    <= cfg_data[CAP_W-1:0];
                CFG_WARMUP_COUNT: warmup_count_reg <= cfg_data[CNT_W-1:0];
                CFG_TERM_MODE:    term_mode_reg    <= cfg_data[0];
                CFG_MAX_SERVED:   max_served_reg   <= cfg_data[CNT_W-1:0];
                CFG_HORIZON:      horizon_reg      <= cfg_data[HOR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- arrival RAM ----------------
    always_comb
    begin
        ram_req.re    = in_fire;
        ram_req.raddr = head_ptr_reg;
        ram_req.we    = (state_reg == ST_CALC) && !ev_dep_reg && !reject;
        ram_req.waddr = tail_ptr_reg;
        ram_req.wdata = ev_time_reg;
    end

    qes_arrival_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // ---------------- event decode ----------------
    always_comb
    begin
        busy_now       = server_busy_reg;
        warm_pre       = served_all_reg >= warmup_count_reg;
        integ          = (ev_time_reg > last_time_reg) && warm_pre;
        dt             = ev_time_reg - last_time_reg;
        waiting        = (occupancy_reg > OCC_W'(busy_now)) ?
                         occupancy_reg - OCC_W'(busy_now) : '0;
        occ_dec        = occupancy_reg - 1'b1;
        reject         = (occupancy_reg >= OCC_W'(FIFO_DEPTH)) ||
                         (busy_now && cap_enable_reg && (occupancy_reg != '0) &&
                          (32'(occ_dec) >= 32'(cap_limit_reg)));
        dep_delay      = (ev_time_reg >= ram_rdata) ? ev_time_reg - ram_rdata : '0;
        served_all_inc = (served_all_reg != '1) ? served_all_reg + 1'b1 : served_all_reg;
        warm_post      = served_all_inc >= warmup_count_reg;
    end

    always_comb
    begin
        prod_ext = {{ACC_W{1'b0}}, prod_reg};
        prod_sat = (prod_ext[ACC_W+PROD_W-1:ACC_W] != '0) ? '1 : prod_ext[ACC_W-1:0];
    end

    always_comb
    begin
        if (served_all_reg < warmup_count_reg)
        begin
            term = 1'b0;
        end
        else if (!term_mode_reg)
        begin
            term = served_post_reg >= max_served_reg;
        end
        else
        begin
            term = (last_time_reg >= warm_end_reg) &&
                   (64'(last_time_reg - warm_end_reg) >= 64'(horizon_reg));
        end
    end

    // ---------------- event capture ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ev_dep_reg  <= req_type;
            ev_time_reg <= event_time;
        end
    end

    // ---------------- datapath (CALC/ACC) ----------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            prod_reg      <= integ ? PROD_W'(waiting) * PROD_W'(dt) : '0;
            busy_inc_reg  <= (integ && busy_now) ? dt : '0;
            if (!ev_dep_reg)
            begin
                res_acc_reg   <= !reject;
                res_start_reg <= !reject && !busy_now;
                res_empty_reg <= 1'b0;
                res_delay_reg <= '0;
                delay_add_reg <= '0;
            end
            else if (occupancy_reg == '0)
            begin
                res_acc_reg   <= 1'b1;
                res_start_reg <= 1'b0;
                res_empty_reg <= 1'b1;
                res_delay_reg <= '0;
                delay_add_reg <= '0;
            end
            else
            begin
                res_acc_reg   <= 1'b1;
                res_start_reg <= (occ_dec != '0);
                res_empty_reg <= 1'b0;
                res_delay_reg <= dep_delay;
                delay_add_reg <= warm_post ? dep_delay : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg    <= '0;
            tail_ptr_reg    <= '0;
            occupancy_reg   <= '0;
            server_busy_reg <= 1'b0;
            last_time_reg   <= '0;
            served_all_reg  <= '0;
            served_post_reg <= '0;
            warm_end_reg    <= '0;
            queue_area_reg  <= '0;
            busy_area_reg   <= '0;
            delay_sum_reg   <= '0;
        end
        else if (state_reg == ST_CALC)
        begin
            last_time_reg <= ev_time_reg;
            if (!ev_dep_reg)
            begin
                if (!reject)
                begin
                    tail_ptr_reg    <= ptr_inc(tail_ptr_reg);
                    occupancy_reg   <= occupancy_reg + 1'b1;
                    server_busy_reg <= 1'b1;
                end
            end
            else if (occupancy_reg == '0)
            begin
                server_busy_reg <= 1'b0;
            end
            else
            begin
                head_ptr_reg    <= ptr_inc(head_ptr_reg);
                occupancy_reg   <= occ_dec;
                server_busy_reg <= (occ_dec != '0);
                served_all_reg  <= served_all_inc;
                if ((served_all_reg != '1) && (served_all_inc == warmup_count_reg))
                begin
                    warm_end_reg <= ev_time_reg;
                end
                if (warm_post && (served_post_reg != '1))
                begin
                    served_post_reg <= served_post_reg + 1'b1;
                end
            end
        end
        else if (state_reg == ST_ACC)
        begin
            queue_area_reg <= sat_add(queue_area_reg, prod_sat);
            busy_area_reg  <= sat_add(busy_area_reg, ACC_W'(busy_inc_reg));
            delay_sum_reg  <= sat_add(delay_sum_reg, ACC_W'(delay_add_reg));
        end
    end

    // ---------------- output word ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_acc_reg    <= res_acc_reg;
            o_start_reg  <= res_start_reg;
            o_empty_reg  <= res_empty_reg;
            o_delay_reg  <= res_delay_reg;
            o_occ_reg    <= occupancy_reg;
            o_aq_reg     <= queue_area_reg;
            o_ab_reg     <= busy_area_reg;
            o_td_reg     <= delay_sum_reg;
            o_served_reg <= served_post_reg;
            o_warm_reg   <= warm_end_reg;
            o_term_reg   <= term;
        end
    end

    assign out_valid       = out_valid_reg;
    assign accepted        = o_acc_reg;
    assign start_service   = o_start_reg;
    assign empty_departure = o_empty_reg;
    assign delay           = o_delay_reg;
    assign in_system       = o_occ_reg;
    assign area_queue      = o_aq_reg;
    assign area_busy       = o_ab_reg;
    assign total_delay     = o_td_reg;
    assign served_count    = o_served_reg;
    assign warmup_end_time = o_warm_reg;
    assign terminate       = o_term_reg;

    // ---------------- checks ----------------
    `QES_ASSERT_NOW(a_occ_bound, 1'b1, occupancy_reg <= OCC_W'(FIFO_DEPTH),
        "occupancy above FIFO depth")
    `QES_ASSERT_NOW(a_busy_occ, 1'b1, server_busy_reg == (occupancy_reg != '0),
        "server busy flag disagrees with occupancy")
    `QES_ASSERT_NEXT(a_fire_calc, in_fire, state_reg == ST_CALC,
        "accepted event did not enter CALC")
    `QES_ASSERT_NEXT(a_occ_hold, state_reg != ST_CALC, $stable(occupancy_reg),
        "occupancy changed outside CALC")

endmodule

// ===== rtl/qes_arrival_ram.sv =====
module qes_arrival_ram (
    input  logic                      clk,
    input  qes_pkg::ram_req_t         req,
    output logic [qes_pkg::TIME_W-1:0] rdata
);
    import qes_pkg::*;

    logic [TIME_W-1:0] mem [FIFO_DEPTH];
    logic [TIME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
